/* rtl/four_level_page_table_walker_macros.svh */
// Assertion macros used by the checker file of the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FLPTW_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FLPTW_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/flptw_pkg.sv */
// Shared types, constants and helpers of the four-level page table walker.
`timescale 1ns / 1ps

package flptw_pkg;

    // Store geometry
    localparam int TABLE_PAGES_DEF   = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;

    // Field widths
    localparam int OP_W       = 2;
    localparam int EADDR_W    = 13;
    localparam int ENTRY_W    = 64;
    localparam int VA_W       = 48;
    localparam int ROOT_W     = 4;
    localparam int FAULT_W    = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 72;

    // Entry layout
    localparam int PAGE_SHIFT   = 12;
    localparam int PN_W         = ENTRY_W - PAGE_SHIFT;
    localparam int BIT_PRESENT  = 0;
    localparam int BIT_WRITABLE = 1;
    localparam int BIT_HUGE     = 7;

    // Index positions in the virtual address
    localparam int SHIFT_PML4 = 39;
    localparam int SHIFT_PDPT = 30;
    localparam int SHIFT_PD   = 21;
    localparam int SHIFT_PT   = 12;

    // Walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_PT   = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_XLATE = 2'd1,
        OP_UNMAP = 2'd2,
        OP_SETWR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [EADDR_W-1:0]   entry_addr;
        logic [ENTRY_W-1:0]   entry_value;
        logic [VA_W-1:0]      vaddr;
        logic                 write_enable_bit;
    } t_item;

    typedef struct packed {
        logic                 present;
        logic                 huge;
        logic [ENTRY_W-1:0]   leaf_entry;
        logic [FAULT_W-1:0]   fault_level;
        logic                 bad_pointer;
        logic                 changed;
    } t_result;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

    // Pick the 9-bit table index of one walk level
    function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0]      lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = va[SHIFT_PML4 +: IDX_W];
            LVL_PDPT: idx = va[SHIFT_PDPT +: IDX_W];
            LVL_PD:   idx = va[SHIFT_PD +: IDX_W];
            LVL_PT:   idx = va[SHIFT_PT +: IDX_W];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

endpackage

/* rtl/four_level_page_table_walker.sv */
// Top level of the four-level page table walker: ports, root register, store and walker.
//
// Input stream (s side): one transfer is one command. tuser carries op (write entry,
// translate, unmap leaf, set writable bit); tdata carries the operands.
// Output stream (m side): exactly one result transfer per command, in command order.
// Config channel: writes root_page, the store page of the top-level table; always ready.
// Timing: an entry write or a walk aborted on a bad root pointer is finished in the
// idle state that takes the command. A walk reads one table level per lookup step;
// the chain of dependent reads through the one-port store sets its length.
// Unmap and set-writable write the leaf back in the same cycle that evaluates it.
// Reset: the root register returns to 0 and a clearing pass writes zero to every store
// word, one word a cycle, TABLE_PAGES * 512 words (8192 by default); s_tready stays
// low until it ends.
// Stall: a finished result sits in an output register while the next command is taken;
// a second result waits in the walker until the receiver takes the first.
`timescale 1ns / 1ps

module four_level_page_table_walker #(
    parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: entry_addr[12:0], entry_value[76:13], virt_addr[124:77],
    //        write_enable_bit[125], zero pad[127:126]
    input  logic [flptw_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: op[1:0]
    input  logic [flptw_pkg::OP_W-1:0]         i_s_tuser,
    // Result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: present[0], huge[1], leaf_entry[65:2], fault_level[68:66],
    //        bad_pointer[69], changed[70], zero pad[71]
    output logic [flptw_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // Root page configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [flptw_pkg::ROOT_W-1:0]       i_cfg_data
);

    localparam int STORE_WORDS = TABLE_PAGES * flptw_pkg::ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    logic [flptw_pkg::ROOT_W-1:0]  r_root;
    flptw_pkg::t_item              item;
    flptw_pkg::t_result            res;
    flptw_pkg::t_mem_ctl           mem_ctl;
    logic [ADDR_W-1:0]             mem_addr;
    logic [flptw_pkg::ENTRY_W-1:0] mem_wdata;
    logic [flptw_pkg::ENTRY_W-1:0] mem_rdata;

    // Hold the root page on each config transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_valid) begin
            r_root <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Unpack the command
    assign item.op               = flptw_pkg::t_op'(i_s_tuser);
    assign item.entry_addr       = i_s_tdata[12:0];
    assign item.entry_value      = i_s_tdata[76:13];
    assign item.vaddr            = i_s_tdata[124:77];
    assign item.write_enable_bit = i_s_tdata[125];

    // Pack the result
    assign o_m_tdata = {1'b0, res.changed, res.bad_pointer, res.fault_level,
                        res.leaf_entry, res.huge, res.present};

    flptw_walk #(
        .TABLE_PAGES (TABLE_PAGES),
        .STORE_WORDS (STORE_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (item),
        .i_root      (r_root),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out       (res),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    flptw_store #(
        .DEPTH  (STORE_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

/* rtl/flptw_store.sv */
// Single-port synchronous table store with registered read data.
`timescale 1ns / 1ps

module flptw_store #(
    parameter int DEPTH  = flptw_pkg::TABLE_PAGES_DEF * flptw_pkg::ENTRIES_PER_TABLE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                           i_clk,
    input  flptw_pkg::t_mem_ctl            i_ctl,
    input  logic [ADDR_W-1:0]              i_addr,
    input  logic [flptw_pkg::ENTRY_W-1:0]  i_wdata,
    output logic [flptw_pkg::ENTRY_W-1:0]  o_rdata
);

    logic [flptw_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [flptw_pkg::ENTRY_W-1:0] r_rdata;

    // Write and read one word; read returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/flptw_walk.sv */
// Walk sequencer: clearing pass, table reads, leaf write-back and result register.
`timescale 1ns / 1ps

module flptw_walk #(
    parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES_DEF,
    parameter int STORE_WORDS = TABLE_PAGES * flptw_pkg::ENTRIES_PER_TABLE,
    parameter int ADDR_W      = $clog2(STORE_WORDS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  flptw_pkg::t_item               i_item,
    input  logic [flptw_pkg::ROOT_W-1:0]   i_root,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output flptw_pkg::t_result             o_out,
    output flptw_pkg::t_mem_ctl            o_mem_ctl,
    output logic [ADDR_W-1:0]              o_mem_addr,
    output logic [flptw_pkg::ENTRY_W-1:0]  o_mem_wdata,
    input  logic [flptw_pkg::ENTRY_W-1:0]  i_mem_rdata
);

    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int EXT_W  = (ADDR_W > flptw_pkg::EADDR_W) ? ADDR_W : flptw_pkg::EADDR_W;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_WORDS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FIN
    } t_state;

    t_state                          r_state;
    logic [ADDR_W-1:0]               r_clr;
    logic [ADDR_W-1:0]               r_addr;
    logic [1:0]                      r_lvl;
    flptw_pkg::t_op                  r_op;
    logic [flptw_pkg::VA_W-1:0]      r_va;
    logic                            r_wen;
    flptw_pkg::t_result              r_res;
    flptw_pkg::t_result              r_out;
    logic                            r_out_valid;

    flptw_pkg::t_mem_ctl             mem_ctl;
    logic [ADDR_W-1:0]               mem_addr;
    logic [flptw_pkg::ENTRY_W-1:0]   mem_wdata;
    flptw_pkg::t_result              res;
    logic                            fin;
    logic                            out_free;
    logic                            out_load;
    logic                            root_bad;
    logic                            wr_in_range;
    logic                            next_bad;
    logic [EXT_W-1:0]                eaddr_ext;
    logic [flptw_pkg::ENTRY_W-1:0]   e;

    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = out_free && (fin || (r_state == ST_FIN));
    assign root_bad    = 32'(i_root) >= TABLE_PAGES;
    assign wr_in_range = 32'(i_item.entry_addr) < STORE_WORDS;
    assign eaddr_ext   = EXT_W'(i_item.entry_addr);
    assign e           = i_mem_rdata;
    assign next_bad    = e[flptw_pkg::ENTRY_W-1:flptw_pkg::PAGE_SHIFT]
                         >= flptw_pkg::PN_W'(TABLE_PAGES);

    // Drive the store port and form the result of the current step
    always_comb begin
        mem_ctl   = '0;
        mem_addr  = r_addr;
        mem_wdata = '0;
        res       = '0;
        fin       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_ctl.en = 1'b1;
                mem_ctl.we = 1'b1;
                mem_addr   = r_clr;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_item.op == flptw_pkg::OP_WRITE) begin
                        // Entry write goes straight to the store
                        if (wr_in_range) begin
                            mem_ctl.en  = 1'b1;
                            mem_ctl.we  = 1'b1;
                            mem_addr    = eaddr_ext[ADDR_W-1:0];
                            mem_wdata   = i_item.entry_value;
                            res.changed = 1'b1;
                        end
                        fin = 1'b1;
                    end else if (root_bad) begin
                        res.bad_pointer = 1'b1;
                        fin             = 1'b1;
                    end else begin
                        // Read the top-level entry
                        mem_ctl.en = 1'b1;
                        mem_addr   = (ADDR_W'(i_root) << flptw_pkg::IDX_W)
                                     | ADDR_W'(flptw_pkg::table_index(i_item.vaddr,
                                                                      flptw_pkg::LVL_PML4));
                    end
                end
            end
            ST_LOOKUP: begin
                if (r_lvl == flptw_pkg::LVL_PT) begin
                    // Leaf in the page table
                    res.leaf_entry  = e;
                    res.present     = e[flptw_pkg::BIT_PRESENT];
                    res.fault_level = e[flptw_pkg::BIT_PRESENT] ? flptw_pkg::FAULT_NONE
                                                               : flptw_pkg::FAULT_PT;
                    if (r_op == flptw_pkg::OP_UNMAP && e[flptw_pkg::BIT_PRESENT]) begin
                        mem_ctl.en  = 1'b1;
                        mem_ctl.we  = 1'b1;
                        res.changed = 1'b1;
                    end else if (r_op == flptw_pkg::OP_SETWR) begin
                        mem_ctl.en                        = 1'b1;
                        mem_ctl.we                        = 1'b1;
                        mem_wdata                         = e;
                        mem_wdata[flptw_pkg::BIT_WRITABLE] = r_wen;
                        res.changed                       = 1'b1;
                    end
                    fin = 1'b1;
                end else if (!e[flptw_pkg::BIT_PRESENT]) begin
                    res.fault_level = flptw_pkg::FAULT_W'(r_lvl) + flptw_pkg::FAULT_W'(1);
                    fin             = 1'b1;
                end else if (r_lvl == flptw_pkg::LVL_PD && e[flptw_pkg::BIT_HUGE]) begin
                    // Huge page leaf; set-writable leaves it alone
                    res.leaf_entry = e;
                    res.present    = 1'b1;
                    res.huge       = 1'b1;
                    if (r_op == flptw_pkg::OP_UNMAP) begin
                        mem_ctl.en  = 1'b1;
                        mem_ctl.we  = 1'b1;
                        res.changed = 1'b1;
                    end
                    fin = 1'b1;
                end else if (next_bad) begin
                    res.bad_pointer = 1'b1;
                    fin             = 1'b1;
                end else begin
                    // Descend to the next table
                    mem_ctl.en = 1'b1;
                    mem_addr   = (ADDR_W'(e[flptw_pkg::PAGE_SHIFT +: PAGE_W])
                                  << flptw_pkg::IDX_W)
                                 | ADDR_W'(flptw_pkg::table_index(r_va, r_lvl + 2'(1)));
                end
            end
            default: begin
            end
        endcase
    end

    // Sequence state and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Set on a load, drop once the receiver takes the transfer
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op   <= i_item.op;
                        r_va   <= i_item.vaddr;
                        r_wen  <= i_item.write_enable_bit;
                        r_addr <= mem_addr;
                        r_lvl  <= flptw_pkg::LVL_PML4;
                        if (fin) begin
                            if (out_free) begin
                                r_out <= res;
                            end else begin
                                r_res   <= res;
                                r_state <= ST_FIN;
                            end
                        end else begin
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                ST_LOOKUP: begin
                    if (fin) begin
                        if (out_free) begin
                            r_out   <= res;
                            r_state <= ST_IDLE;
                        end else begin
                            r_res   <= res;
                            r_state <= ST_FIN;
                        end
                    end else begin
                        r_lvl  <= r_lvl + 2'(1);
                        r_addr <= mem_addr;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_mem_ctl   = mem_ctl;
    assign o_mem_addr  = mem_addr;
    assign o_mem_wdata = mem_wdata;

endmodule

/* rtl/flptw_checker.sv */
// Port-level checker of the page table walker and its bind to the top level.
`timescale 1ns / 1ps
`include "four_level_page_table_walker_macros.svh"

module flptw_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [flptw_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    logic s_xfer;
    logic m_stall;

    assign s_xfer  = i_s_tvalid && o_s_tready;
    assign m_stall = o_m_tvalid && !i_m_tready;

    // Reset starts the clearing pass: no command is taken right after it
    `FLPTW_ASSERT_ALL(a_reset_blocks_input, !i_rst_n |=> !o_s_tready, "input ready after reset")

    // Reset drops any pending result
    `FLPTW_ASSERT_ALL(a_reset_drops_output, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // A stalled result holds its value
    `FLPTW_ASSERT_RUN(a_stall_hold, m_stall |=> o_m_tvalid && $stable(o_m_tdata), "result changed")

    // A command taken while the output is blocked leaves the walker busy
    `FLPTW_ASSERT_RUN(a_busy_full, s_xfer && m_stall |=> !o_s_tready, "input not held off")

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (.*);

/* bench/four_level_page_table_walker_tb.sv */
// Self-checking testbench for the four-level page table walker: directed and random command streams.
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
    import flptw_pkg::*;

    localparam int STORE_PAGES = TABLE_PAGES_DEF;
    localparam int STORE_WORDS = STORE_PAGES * ENTRIES_PER_TABLE;

    localparam logic [63:0] MASK_PRESENT  = 64'd1 << BIT_PRESENT;
    localparam logic [63:0] MASK_WRITABLE = 64'd1 << BIT_WRITABLE;
    localparam logic [63:0] MASK_HUGE     = 64'd1 << BIT_HUGE;

    typedef struct {
        logic        present;
        logic        huge;
        logic [63:0] leaf;
        logic [2:0]  fault;
        logic        bad;
        logic        have_leaf;
        int          leaf_addr;
    } t_walk_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [OP_W-1:0]       i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [ROOT_W-1:0]     i_cfg_data;

    // Shadow copy of the store and the root register
    logic [63:0]     shadow_store [0:STORE_WORDS-1];
    logic [3:0]      shadow_root;
    t_result         pending_results [$];
    logic [47:0]     recent_vas [$];
    int              commands_sent;
    int              mismatches;
    int              sender_idle_pct;
    int              receiver_stall_pct;

    four_level_page_table_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if the stream hangs
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [47:0] rand_va();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // 9-bit table index of one walk level
    function automatic logic [8:0] va_index(input logic [47:0] va, input int lvl);
        case (2'(lvl))
            LVL_PML4: return va[SHIFT_PML4 +: 9];
            LVL_PDPT: return va[SHIFT_PDPT +: 9];
            LVL_PD:   return va[SHIFT_PD +: 9];
            default:  return va[SHIFT_PT +: 9];
        endcase
    endfunction

    function automatic logic [12:0] slot_addr(input logic [63:0] page, input logic [47:0] va,
                                              input int lvl);
        return 13'(page * ENTRIES_PER_TABLE + 64'(va_index(va, lvl)));
    endfunction

    // Present pointer to a table page with random flag bits, huge bit clear
    function automatic logic [63:0] table_pointer(input int page);
        return (64'(page) << PAGE_SHIFT) | (64'($urandom_range(4095)) & ~MASK_HUGE)
               | MASK_PRESENT;
    endfunction

    // Walk the shadow tables for one virtual address
    function automatic t_walk_outcome walk_tables(input logic [47:0] va);
        t_walk_outcome w;
        logic [63:0]   page;
        logic [63:0]   e;
        int            addr;
        w = '{default: '0};
        page = 64'(shadow_root);
        for (int lvl = 0; lvl < 4; lvl++) begin
            if (page >= 64'(STORE_PAGES)) begin
                w.bad = 1'b1;
                return w;
            end
            addr = int'(page) * ENTRIES_PER_TABLE + int'(va_index(va, lvl));
            e = shadow_store[addr];
            if (2'(lvl) == LVL_PT) begin
                w.have_leaf = 1'b1;
                w.leaf_addr = addr;
                w.leaf      = e;
                w.present   = e[BIT_PRESENT];
                if (!e[BIT_PRESENT])
                    w.fault = FAULT_PT;
                return w;
            end
            if (!e[BIT_PRESENT]) begin
                w.fault = 3'(lvl + 1);
                return w;
            end
            if (2'(lvl) == LVL_PD && e[BIT_HUGE]) begin
                w.have_leaf = 1'b1;
                w.leaf_addr = addr;
                w.leaf      = e;
                w.present   = 1'b1;
                w.huge      = 1'b1;
                return w;
            end
            page = e >> PAGE_SHIFT;
        end
        return w;
    endfunction

    // Apply one accepted command to the shadow state and queue its result
    function automatic void predict_command(input t_op op, input logic [12:0] addr,
                                            input logic [63:0] value, input logic [47:0] va,
                                            input logic wen);
        t_walk_outcome w;
        t_result       r;
        logic          changed;
        w = '{default: '0};
        changed = 1'b0;
        if (op == OP_WRITE) begin
            if (int'(addr) < STORE_WORDS) begin
                shadow_store[addr] = value;
                changed = 1'b1;
            end
        end else begin
            w = walk_tables(va);
            if (op == OP_UNMAP && w.have_leaf && w.present) begin
                shadow_store[w.leaf_addr] = '0;
                changed = 1'b1;
            end else if (op == OP_SETWR && w.have_leaf && !w.huge) begin
                shadow_store[w.leaf_addr] = wen ? (w.leaf | MASK_WRITABLE)
                                                : (w.leaf & ~MASK_WRITABLE);
                changed = 1'b1;
            end
        end
        r.present     = w.present;
        r.huge        = w.huge;
        r.leaf_entry  = w.leaf;
        r.fault_level = w.fault;
        r.bad_pointer = w.bad;
        r.changed     = changed;
        pending_results.push_back(r);
    endfunction

    // Drive one command and hold it until the transfer; called and returns at a falling edge
    task automatic send_command(input t_op op, input logic [12:0] addr, input logic [63:0] value,
                                input logic [47:0] va, input logic wen);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, wen, va, value, addr};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1)
            @(posedge i_clk);
        predict_command(op, addr, value, va, wen);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_entry(input logic [12:0] addr, input logic [63:0] value);
        send_command(OP_WRITE, addr, value, rand_va(), 1'($urandom));
    endtask

    task automatic walk_command(input t_op op, input logic [47:0] va, input logic wen);
        send_command(op, 13'($urandom), rand_word(), va, wen);
    endtask

    // Write the entries along the walk of va, stopping at a huge leaf or a bad pointer
    task automatic build_mapping(input logic [47:0] va, input logic [63:0] entries [4]);
        logic [63:0] page;
        page = 64'(shadow_root);
        for (int lvl = 0; lvl < 4; lvl++) begin
            if (page >= 64'(STORE_PAGES))
                break;
            write_entry(slot_addr(page, va, lvl), entries[lvl]);
            if (2'(lvl) == LVL_PD && entries[lvl][BIT_HUGE])
                break;
            page = entries[lvl] >> PAGE_SHIFT;
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_root(input logic [3:0] root);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= root;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        shadow_root = root;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("present",     64'(want.present),     64'(o_m_tdata[0]));
                check_field("huge",        64'(want.huge),        64'(o_m_tdata[1]));
                check_field("leaf_entry",  want.leaf_entry,       o_m_tdata[65:2]);
                check_field("fault_level", 64'(want.fault_level), 64'(o_m_tdata[68:66]));
                check_field("bad_pointer", 64'(want.bad_pointer), 64'(o_m_tdata[69]));
                check_field("changed",     64'(want.changed),     64'(o_m_tdata[70]));
            end
        end
    end

    // Stall the result side at the rate of the current phase
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Walks over a cleared store fault at the top level
    task automatic test_empty_store();
        set_root(4'd0);
        walk_command(OP_XLATE, '0, 1'b0);
        walk_command(OP_UNMAP, '1, 1'b1);
        walk_command(OP_SETWR, rand_va(), 1'b1);
    endtask

    // Entry writes at the ends of the store, and an all-ones entry as a bad pointer
    task automatic test_entry_writes();
        write_entry('0, '1);
        walk_command(OP_XLATE, '0, 1'b0);
        write_entry('1, '1);
        write_entry('0, '0);
    endtask

    // Full four-level walk, writable bit updates, unmap and faults at the PDPT, PD and PT levels
    task automatic test_four_level_walk();
        logic [47:0] va;
        va = '1;
        set_root(4'd15);
        build_mapping(va, '{table_pointer(3), table_pointer(7), table_pointer(0),
                            rand_word() | MASK_PRESENT});
        walk_command(OP_XLATE, va, 1'b0);
        walk_command(OP_SETWR, va, 1'b1);
        walk_command(OP_SETWR, va, 1'b0);
        walk_command(OP_UNMAP, va, 1'b0);
        walk_command(OP_XLATE, va, 1'b0);
        walk_command(OP_SETWR, va, 1'b1);
        walk_command(OP_UNMAP, va, 1'b1);
        walk_command(OP_XLATE, va ^ (48'd1 << SHIFT_PDPT), 1'b0);
        walk_command(OP_XLATE, va ^ (48'd1 << SHIFT_PD), 1'b0);
    endtask

    // Huge PD leaf: translate, writable update skipped, unmap; then a pointer with bit 63 set
    task automatic test_huge_and_bad_pointer();
        build_mapping('0, '{table_pointer(1), table_pointer(2),
                            rand_word() | MASK_PRESENT | MASK_HUGE, '0});
        walk_command(OP_XLATE, '0, 1'b0);
        walk_command(OP_SETWR, '0, 1'b1);
        walk_command(OP_UNMAP, '0, 1'b0);
        build_mapping('0, '{table_pointer(1), table_pointer(2) | (64'd1 << 63), '0, '0});
        walk_command(OP_XLATE, 48'hFFF, 1'b0);
    endtask

    // Mostly well-formed mappings followed by walks on them, plus random noise
    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                       input logic [3:0] root);
        logic [63:0] entries [4];
        logic [47:0] va;
        int          goal;
        int          pick;
        int          lvl;
        t_op         op;
        set_root(root);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        goal = commands_sent + items;
        while (commands_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                // noise: any command with random fields
                op = t_op'(2'($urandom));
                send_command(op, 13'($urandom),
                             ($urandom_range(1) != 0) ? rand_word()
                                                      : table_pointer($urandom_range(15)),
                             rand_va(), 1'($urandom));
            end else begin
                if (pick < 45 && recent_vas.size() != 0) begin
                    // revisit a mapped address, maybe another PT slot of it
                    va = recent_vas[$urandom_range(recent_vas.size() - 1)];
                    if ($urandom_range(1) != 0)
                        va[SHIFT_PT +: 9] = 9'($urandom);
                end else begin
                    va = rand_va();
                    entries[0] = table_pointer($urandom_range(15));
                    entries[1] = table_pointer($urandom_range(15));
                    entries[2] = table_pointer($urandom_range(15));
                    entries[3] = rand_word() | MASK_PRESENT;
                    case ($urandom_range(9))
                        0, 1: entries[2] = rand_word() | MASK_PRESENT | MASK_HUGE;
                        2: begin
                            lvl = $urandom_range(3);
                            entries[lvl] = entries[lvl] & ~MASK_PRESENT;
                        end
                        3: begin
                            lvl = $urandom_range(2);
                            entries[lvl] = entries[lvl] | (64'd1 << $urandom_range(63, 16));
                        end
                        default: ;
                    endcase
                    build_mapping(va, entries);
                    recent_vas.push_back(va);
                    if (recent_vas.size() > 16)
                        void'(recent_vas.pop_front());
                end
                repeat ($urandom_range(4, 1)) begin
                    op = t_op'(2'($urandom_range(int'(OP_SETWR), int'(OP_XLATE))));
                    walk_command(op, va ^ 48'($urandom_range(4095)), 1'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_s_tvalid         = 1'b0;
        i_s_tdata          = '0;
        i_s_tuser          = '0;
        i_m_tready         = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        shadow_root        = '0;
        commands_sent      = 0;
        mismatches         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < STORE_WORDS; i++)
            shadow_store[i] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_entry_writes();
        test_four_level_walk();
        test_huge_and_bad_pointer();
        test_random_traffic(250, 0, 0, 4'd15);
        test_random_traffic(250, 68, 0, 4'($urandom));
        test_random_traffic(250, 0, 68, 4'd0);
        test_random_traffic(250, 35, 35, 4'($urandom));

        // Drain the last results and allow the walk latency to pass
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
